[src/sps_pkg.sv]
package sps_pkg;

  localparam int LIMIT_W   = 16;
  localparam int CODE_W    = 3;
  localparam int CFG_IDX_W = 2;

  // Phase register, one-hot
  typedef enum logic [5:0] {
    PH_OFF   = 6'b000001,
    PH_HOLD  = 6'b000010,
    PH_WARM  = 6'b000100,
    PH_SETUP = 6'b001000,
    PH_RUN   = 6'b010000,
    PH_COOL  = 6'b100000
  } phase_t;

  localparam logic [CODE_W-1:0] CODE_OFF   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_HOLD  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_WARM  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_SETUP = 3'd3;
  localparam logic [CODE_W-1:0] CODE_RUN   = 3'd4;
  localparam logic [CODE_W-1:0] CODE_COOL  = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_OFF      = 2'd0,
    REG_WARMUP        = 2'd1,
    REG_FILTER_WARMUP = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] hold_off_ms;
    logic [LIMIT_W-1:0] warmup_ms;
    logic [LIMIT_W-1:0] filter_warmup_ms;
  } cfg_t;

  typedef struct packed {
    logic ms_tick;
    logic power_up_request;
    logic power_down_request;
    logic setup_ok;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0] phase_code;
    logic              power_off;
    logic              filter_ready;
    logic              setup_strobe;
  } result_t;

  function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
    logic [CODE_W-1:0] code;
    unique case (ph)
      PH_OFF:   code = CODE_OFF;
      PH_HOLD:  code = CODE_HOLD;
      PH_WARM:  code = CODE_WARM;
      PH_SETUP: code = CODE_SETUP;
      PH_RUN:   code = CODE_RUN;
      PH_COOL:  code = CODE_COOL;
      default:  code = CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

[src/sps_if.sv]
interface sps_in_if;
  logic valid;
  logic ready;
  logic ms_tick;
  logic power_up_request;
  logic power_down_request;
  logic setup_ok;

  modport source (output valid, output ms_tick, output power_up_request,
                  output power_down_request, output setup_ok, input ready);
  modport sink   (input valid, input ms_tick, input power_up_request,
                  input power_down_request, input setup_ok, output ready);
endinterface

interface sps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase_code;
  logic       power_off;
  logic       filter_ready;
  logic       setup_strobe;

  modport source (output valid, output phase_code, output power_off,
                  output filter_ready, output setup_strobe, input ready);
  modport sink   (input valid, input phase_code, input power_off,
                  input filter_ready, input setup_strobe, output ready);
endinterface

interface sps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/sps_cfg_regs.sv]
module sps_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [sps_pkg::CFG_IDX_W-1:0]     wr_idx,
  input  logic [sps_pkg::LIMIT_W-1:0]       wr_data,
  output sps_pkg::cfg_t                     cfg
);
  import sps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_idx))
        REG_HOLD_OFF:      cfg_nxt.hold_off_ms      = wr_data;
        REG_WARMUP:        cfg_nxt.warmup_ms        = wr_data;
        REG_FILTER_WARMUP: cfg_nxt.filter_warmup_ms = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_off_ms      <= LIMIT_W'(500);
      cfg_r.warmup_ms        <= LIMIT_W'(200);
      cfg_r.filter_warmup_ms <= LIMIT_W'(1000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/sps_core.sv]
module sps_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  sps_pkg::item_t   item,
  input  sps_pkg::cfg_t    cfg,
  output sps_pkg::result_t res
);
  import sps_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > LIMIT_W) ? TIMER_WIDTH : LIMIT_W;

  phase_t                 phase_r,      phase_nxt;
  logic [TIMER_WIDTH-1:0] elapsed_r,    elapsed_nxt;
  logic                   up_pend_r,    up_pend_nxt;
  logic                   down_pend_r,  down_pend_nxt;
  logic                   supply_off_r, supply_off_nxt;
  logic                   warmed_r,     warmed_nxt;
  logic                   strobe;
  logic [TIMER_WIDTH-1:0] t_tick;
  logic [CMP_W-1:0]       t_ext;

  // Saturating tick, added before the phase compare
  assign t_tick = (item.ms_tick && (elapsed_r != '1)) ? elapsed_r + 1'b1 : elapsed_r;
  assign t_ext  = CMP_W'(t_tick);

  always_comb begin
    phase_nxt      = phase_r;
    elapsed_nxt    = t_tick;
    up_pend_nxt    = up_pend_r | item.power_up_request;
    down_pend_nxt  = down_pend_r | item.power_down_request;
    supply_off_nxt = supply_off_r;
    warmed_nxt     = warmed_r;
    strobe         = 1'b0;
    unique case (phase_r)
      PH_OFF: begin
        if (up_pend_nxt) begin
          up_pend_nxt    = 1'b0;
          supply_off_nxt = 1'b1;
          elapsed_nxt    = '0;
          phase_nxt      = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (t_ext > CMP_W'(cfg.hold_off_ms)) begin
          supply_off_nxt = 1'b0;
          elapsed_nxt    = '0;
          phase_nxt      = PH_WARM;
        end
      end
      PH_WARM: begin
        if (t_ext > CMP_W'(cfg.warmup_ms)) begin
          phase_nxt = PH_SETUP;
        end
      end
      PH_SETUP: begin
        strobe      = 1'b1;
        elapsed_nxt = '0;
        if (item.setup_ok) begin
          warmed_nxt = 1'b0;
          phase_nxt  = PH_RUN;
        end else begin
          supply_off_nxt = 1'b1;
          phase_nxt      = PH_COOL;
        end
      end
      PH_RUN: begin
        if (down_pend_nxt) begin
          down_pend_nxt  = 1'b0;
          supply_off_nxt = 1'b1;
          warmed_nxt     = 1'b0;
          elapsed_nxt    = '0;
          phase_nxt      = PH_COOL;
        end else if (t_ext > CMP_W'(cfg.filter_warmup_ms)) begin
          warmed_nxt = 1'b1;
        end
      end
      PH_COOL: begin
        if (t_ext > CMP_W'(cfg.warmup_ms)) begin
          phase_nxt = PH_OFF;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_OFF;
      elapsed_r    <= '0;
      up_pend_r    <= 1'b0;
      down_pend_r  <= 1'b0;
      supply_off_r <= 1'b1;
      warmed_r     <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      elapsed_r    <= elapsed_nxt;
      up_pend_r    <= up_pend_nxt;
      down_pend_r  <= down_pend_nxt;
      supply_off_r <= supply_off_nxt;
      warmed_r     <= warmed_nxt;
    end
  end

  assign res.phase_code   = phase_code(phase_nxt);
  assign res.power_off    = supply_off_nxt;
  assign res.filter_ready = warmed_nxt;
  assign res.setup_strobe = strobe;

endmodule

[src/sensor_power_sequencer.sv]
// Sensor power sequencer.
// Walks a sensor supply through off, hold-off, warm-up, setup attempt,
// running and cool-down, one step per input item.
// Channels:
//   in_ch  : step items (ms_tick, power_up_request, power_down_request, setup_ok)
//   out_ch : one result per item (phase_code, power_off, filter_ready, setup_strobe)
//   cfg_ch : register writes, index 0 hold_off_ms, 1 warmup_ms, 2 filter_warmup_ms;
//            other indexes are dropped. Always ready; write only while idle.
// An accepted item waits in the input register, and its result then in the result
// register. Throughput: one item per cycle while out_ch is not stalled. The input
// register feeds a single pass of phase logic into the result register; the phase
// state updates in the same edge that loads the result register.
// Stall: while out_ch is stalled, the input register still takes one item;
// in_ch.ready drops only when both registers are full.
// Reset (rst_n low, synchronous): phase off, timer zero, requests cleared,
// supply off, filter not ready, both registers empty, config at defaults.
module sensor_power_sequencer #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sps_in_if.sink     in_ch,
  sps_out_if.source  out_ch,
  sps_cfg_if.sink    cfg_ch
);
  import sps_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  result_t res_r;
  result_t res_nxt;
  logic    out_vld_r;
  logic    adv;
  logic    in_take;

  // Configuration: always ready, taken in the same cycle
  assign cfg_ch.ready = 1'b1;

  sps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  // Advance the held item into the result register when there is room
  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.ms_tick            <= in_ch.ms_tick;
      item_r.power_up_request   <= in_ch.power_up_request;
      item_r.power_down_request <= in_ch.power_down_request;
      item_r.setup_ok           <= in_ch.setup_ok;
    end
  end

  sps_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res_nxt)
  );

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.phase_code   = res_r.phase_code;
  assign out_ch.power_off    = res_r.power_off;
  assign out_ch.filter_ready = res_r.filter_ready;
  assign out_ch.setup_strobe = res_r.setup_strobe;

endmodule

[tb/sensor_power_sequencer_tb.sv]
module sensor_power_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 8;
  localparam int TIMER_W     = 16;
  localparam int GAP_MAX     = 18;
  // No handshake on any channel for this many cycles ends the run.
  localparam int QUIET_LIMIT = 2000;
  // Receiver hold-off long enough to fill both stages and stall the input.
  localparam int LONG_HOLD   = 150;
  localparam int SEGMENTS    = 16;
  localparam int SEG_ITEMS   = 85;
  // Ticking steps spent in hold-off on the top limits.
  localparam int TOP_STEPS   = 200;

  // Index past the last register; the block must drop writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [LIMIT_W-1:0]   LIMIT_TOP = 16'd65534;

  // Tracks the supply phase machine and holds the results it expects.
  class phase_tracker;
    cfg_t                 limits;
    logic [CODE_W-1:0]    phase;
    logic [TIMER_W-1:0]   elapsed;
    bit                   up_pend;
    bit                   down_pend;
    bit                   supply_off;
    bit                   warmed;
    result_t              due_results[$];
    int                   errors;

    function new();
      limits     = '{hold_off_ms: 16'd500, warmup_ms: 16'd200, filter_warmup_ms: 16'd1000};
      phase      = CODE_OFF;
      elapsed    = '0;
      up_pend    = 1'b0;
      down_pend  = 1'b0;
      supply_off = 1'b1;
      warmed     = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
      case (idx)
        REG_HOLD_OFF:      limits.hold_off_ms      = val;
        REG_WARMUP:        limits.warmup_ms        = val;
        REG_FILTER_WARMUP: limits.filter_warmup_ms = val;
        default: ;
      endcase
    endfunction

    // Advance one step: latch requests, add the tick, then compare the timer.
    function void take_step(item_t it);
      result_t r;
      bit      strobe;
      strobe = 1'b0;
      if (it.power_up_request)   up_pend   = 1'b1;
      if (it.power_down_request) down_pend = 1'b1;
      if (it.ms_tick && elapsed != '1) elapsed = elapsed + 1'b1;
      case (phase)
        CODE_OFF: begin
          if (up_pend) begin
            up_pend    = 1'b0;
            supply_off = 1'b1;
            elapsed    = '0;
            phase      = CODE_HOLD;
          end
        end
        CODE_HOLD: begin
          if (elapsed > limits.hold_off_ms) begin
            supply_off = 1'b0;
            elapsed    = '0;
            phase      = CODE_WARM;
          end
        end
        CODE_WARM: begin
          if (elapsed > limits.warmup_ms) phase = CODE_SETUP;
        end
        CODE_SETUP: begin
          strobe  = 1'b1;
          elapsed = '0;
          if (it.setup_ok) begin
            warmed = 1'b0;
            phase  = CODE_RUN;
          end else begin
            supply_off = 1'b1;
            phase      = CODE_COOL;
          end
        end
        CODE_RUN: begin
          if (down_pend) begin
            down_pend  = 1'b0;
            supply_off = 1'b1;
            warmed     = 1'b0;
            elapsed    = '0;
            phase      = CODE_COOL;
          end else if (elapsed > limits.filter_warmup_ms) begin
            warmed = 1'b1;
          end
        end
        CODE_COOL: begin
          if (elapsed > limits.warmup_ms) phase = CODE_OFF;
        end
        default: ;
      endcase
      r.phase_code   = phase;
      r.power_off    = supply_off;
      r.filter_ready = warmed;
      r.setup_strobe = strobe;
      due_results.push_back(r);
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none due: phase %0d power_off %0b ready %0b strobe %0b",
                 $time, got.phase_code, got.power_off, got.filter_ready, got.setup_strobe);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.phase_code !== want.phase_code) begin
        $display("%0t: phase_code expected %0d actual %0d", $time, want.phase_code,
                 got.phase_code);
        errors++;
      end
      if (got.power_off !== want.power_off) begin
        $display("%0t: power_off expected %0b actual %0b", $time, want.power_off,
                 got.power_off);
        errors++;
      end
      if (got.filter_ready !== want.filter_ready) begin
        $display("%0t: filter_ready expected %0b actual %0b", $time, want.filter_ready,
                 got.filter_ready);
        errors++;
      end
      if (got.setup_strobe !== want.setup_strobe) begin
        $display("%0t: setup_strobe expected %0b actual %0b", $time, want.setup_strobe,
                 got.setup_strobe);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sps_in_if  step_ch();
  sps_out_if result_ch();
  sps_cfg_if limit_ch();

  sensor_power_sequencer #(
    .TIMER_WIDTH(TIMER_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (step_ch),
    .out_ch (result_ch),
    .cfg_ch (limit_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  phase_tracker tracker;

  // Idle ceilings for each side; zero gives a stretch with no idling.
  int in_gap_max  = 0;
  int out_gap_max = 0;
  // Set by the stimulus to make the receiver hold off once for this many cycles.
  int out_hold_cycles = 0;

  // Observe every handshake at the edge that completes it. All drives are
  // nonblocking, so the values seen here are the ones the block samples.
  always @(posedge clk) begin
    if (rst_n) begin
      if (limit_ch.valid && limit_ch.ready) begin
        tracker.write_reg(limit_ch.index, limit_ch.data);
      end
      if (step_ch.valid && step_ch.ready) begin
        tracker.take_step(item_t'{step_ch.ms_tick, step_ch.power_up_request,
                                  step_ch.power_down_request, step_ch.setup_ok});
      end
      if (result_ch.valid && result_ch.ready) begin
        tracker.match_result(result_t'{result_ch.phase_code, result_ch.power_off,
                                       result_ch.filter_ready, result_ch.setup_strobe});
      end
    end
  end

  // Receiver: draw a stall per item, or serve one long hold-off on request.
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (out_hold_cycles > 0) begin
        stall = out_hold_cycles;
        out_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, out_gap_max);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Watchdog: end the run once no channel has moved for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((step_ch.valid && step_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (limit_ch.valid && limit_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one step item after a drawn gap and hold it until accepted.
  task automatic send_step(input bit tick, input bit up, input bit down, input bit ok);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      step_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    step_ch.valid              <= 1'b1;
    step_ch.ms_tick            <= tick;
    step_ch.power_up_request   <= up;
    step_ch.power_down_request <= down;
    step_ch.setup_ok           <= ok;
    do @(posedge clk); while (!step_ch.ready);
  endtask

  // Drop valid and wait until every expected result has been checked.
  task automatic drain();
    step_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Write all three limits back to back, optionally followed by a spare index.
  task automatic program_limits(input logic [LIMIT_W-1:0] hold, input logic [LIMIT_W-1:0] warm,
                                input logic [LIMIT_W-1:0] filt, input bit spare);
    logic [CFG_IDX_W-1:0] idx_q[$];
    logic [LIMIT_W-1:0]   val_q[$];
    idx_q = '{REG_HOLD_OFF, REG_WARMUP, REG_FILTER_WARMUP};
    val_q = '{hold, warm, filt};
    if (spare) begin
      idx_q.push_back(REG_SPARE);
      val_q.push_back(LIMIT_W'($urandom));
    end
    foreach (idx_q[k]) begin
      limit_ch.valid <= 1'b1;
      limit_ch.index <= idx_q[k];
      limit_ch.data  <= val_q[k];
      do @(posedge clk); while (!limit_ch.ready);
    end
    limit_ch.valid <= 1'b0;
  endtask

  // Mostly short limits so phases turn over; now and then a long one.
  function automatic logic [LIMIT_W-1:0] pick_limit();
    if ($urandom_range(0, 9) == 0) return LIMIT_W'($urandom_range(0, 65534));
    return LIMIT_W'($urandom_range(0, 6));
  endfunction

  // Well-formed traffic: frequent ticks, sparse requests, setup mostly passing.
  // Noise: every bit flips a coin.
  task automatic send_random(input int count, input bit noisy);
    for (int n = 0; n < count; n++) begin
      if (noisy) begin
        send_step($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, 1));
      end else begin
        send_step($urandom_range(0, 3) != 0, $urandom_range(0, 11) == 0,
                  $urandom_range(0, 19) == 0, $urandom_range(0, 4) != 0);
      end
    end
  endtask

  initial begin
    tracker = new();
    rst_n                      <= 1'b0;
    step_ch.valid              <= 1'b0;
    step_ch.ms_tick            <= 1'b0;
    step_ch.power_up_request   <= 1'b0;
    step_ch.power_down_request <= 1'b0;
    step_ch.setup_ok           <= 1'b0;
    limit_ch.valid             <= 1'b0;
    limit_ch.index             <= '0;
    limit_ch.data              <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: start on the reset limits, a down request while off stays
    // latched, a repeated up request waits through hold-off.
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b1, 1'b0);
    send_step(1'b1, 1'b1, 1'b0, 1'b0);
    send_step(1'b1, 1'b1, 1'b0, 1'b1);
    drain();

    // Shrink the limits under a running timer: hold-off ends at once.
    program_limits(16'd0, 16'd1, 16'd2, 1'b1);
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    // Setup passes; the stale down request then ends running right away.
    send_step(1'b0, 1'b0, 1'b0, 1'b1);
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    // Off with the up request still latched: straight back to hold-off.
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    // Setup fails: supply drops, cool-down, then off.
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    // Full clean run up to filter ready, then a down request.
    send_step(1'b0, 1'b1, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 1'b0, 1'b0, 1'b1);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 1'b0, 1'b1, 1'b0);
    drain();

    // Zero limits: every tick passes a compare.
    program_limits(16'd0, 16'd0, 16'd0, 1'b1);
    send_random(20, 1'b0);
    drain();

    // Top limits: hold-off outlasts the whole stretch while the timer counts.
    program_limits(LIMIT_TOP, LIMIT_TOP, LIMIT_TOP, 1'b0);
    send_step(1'b0, 1'b1, 1'b0, 1'b1);
    for (int n = 0; n < TOP_STEPS; n++) send_step(1'b1, 1'b0, 1'b0, 1'b1);
    drain();

    // Random segments, each on fresh limits and idle settings.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      program_limits(pick_limit(), pick_limit(), pick_limit(), $urandom_range(0, 3) == 0);
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      if (seg == 1) begin
        // Hold the receiver off while items keep coming, so the input stalls.
        in_gap_max = 0;
        out_hold_cycles = LONG_HOLD;
      end
      send_random(SEG_ITEMS, $urandom_range(0, 4) == 0);
      drain();
    end

    // Let any stray result show before the verdict.
    repeat (4) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
src/sps_pkg.sv
src/sps_if.sv
src/sps_cfg_regs.sv
src/sps_core.sv
src/sensor_power_sequencer.sv
tb/sensor_power_sequencer_tb.sv
